### src/chord_template_matcher_defines.svh
// ----------------------------------------------------------------------------
// chord_template_matcher_defines.svh
// Assertion macros for the chord matcher checker.
// ----------------------------------------------------------------------------
`ifndef CHORD_TEMPLATE_MATCHER_DEFINES_SVH
`define CHORD_TEMPLATE_MATCHER_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define CTM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg
// Types, chord tables and register constants of the chord template matcher.
// ----------------------------------------------------------------------------
package ctm_pkg;

  localparam int NumBins   = 12;
  localparam int NumChords = 36;
  localparam int IdxW      = 6;
  localparam int ChromaW   = 16;
  localparam int ThrW      = 16;
  localparam int RootW     = 4;

  // Register map
  localparam int  AddrW     = 3;
  localparam int  DataW     = 32;
  localparam logic RegIdxThr = 1'b0;
  localparam logic [ThrW-1:0] ThrReset = 16'd39322;

  typedef enum logic [1:0] {
    QualMaj  = 2'd0,
    QualMin  = 2'd1,
    QualDom7 = 2'd2
  } chord_quality_e;

  // Candidate chords, sorted by text name; the first best one wins a tie.
  localparam logic [RootW-1:0] ChordRoot [NumChords] = '{
    4'd9, 4'd10, 4'd10, 4'd10, 4'd9, 4'd9,
    4'd11, 4'd11, 4'd11,
    4'd0, 4'd1, 4'd1, 4'd1, 4'd0, 4'd0,
    4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2,
    4'd4, 4'd4, 4'd4,
    4'd5, 4'd6, 4'd6, 4'd6, 4'd5, 4'd5,
    4'd7, 4'd8, 4'd8, 4'd8, 4'd7, 4'd7
  };

  localparam chord_quality_e ChordQual [NumChords] = '{
    QualMaj, QualMaj, QualDom7, QualMin, QualDom7, QualMin,
    QualMaj, QualDom7, QualMin,
    QualMaj, QualMaj, QualDom7, QualMin, QualDom7, QualMin,
    QualMaj, QualMaj, QualDom7, QualMin, QualDom7, QualMin,
    QualMaj, QualDom7, QualMin,
    QualMaj, QualMaj, QualDom7, QualMin, QualDom7, QualMin,
    QualMaj, QualMaj, QualDom7, QualMin, QualDom7, QualMin
  };

  typedef struct packed {
    logic [ChromaW-1:0] chroma_c;
    logic [ChromaW-1:0] chroma_cs;
    logic [ChromaW-1:0] chroma_d;
    logic [ChromaW-1:0] chroma_ds;
    logic [ChromaW-1:0] chroma_e;
    logic [ChromaW-1:0] chroma_f;
    logic [ChromaW-1:0] chroma_fs;
    logic [ChromaW-1:0] chroma_g;
    logic [ChromaW-1:0] chroma_gs;
    logic [ChromaW-1:0] chroma_a;
    logic [ChromaW-1:0] chroma_as;
    logic [ChromaW-1:0] chroma_b;
  } chroma_frame_t;

  typedef struct packed {
    logic [RootW-1:0]   chord_root;
    chord_quality_e     chord_quality;
    logic               recognized;
    logic [ChromaW-1:0] best_score;
  } chord_result_t;

  // Pitch class a given interval above a root, modulo 12.
  function automatic logic [RootW-1:0] pc_add(logic [RootW-1:0] root,
                                              logic [RootW-1:0] interval);
    logic [RootW:0] s;
    s = {1'b0, root} + {1'b0, interval};
    if (s >= 5'd12) begin
      s = s - 5'd12;
    end
    return s[RootW-1:0];
  endfunction

endpackage

### src/chord_template_matcher.sv
// ----------------------------------------------------------------------------
// chord_template_matcher
// Chroma template chord recognizer: 36 chords, best mean wins.
// ----------------------------------------------------------------------------
// One chroma frame is taken in each clock cycle: busy stays low, so a frame
// is accepted at every edge with start high. Its result is driven on result_o
// with result_valid_o high for exactly one cycle, after the frame has passed
// through the five stages: the input register, template sums, two halves of
// the compare tree, and the mean and threshold stage. Results come back in
// frame order, one per frame, and cannot be held off by the receiver; it must
// take each one in that cycle. The threshold register is written over the APB
// port; the user must write it only while no frame is in the pipeline, as the
// block itself does not enforce this.
module chord_template_matcher import ctm_pkg::*; #(
  parameter int CHROMA_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Frame in
  input  logic              start,
  output logic              busy,
  input  chroma_frame_t     frame_i,
  // Result out
  output logic              result_valid_o,
  output chord_result_t     result_o,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int BinW = (CHROMA_BITS < ChromaW) ? CHROMA_BITS : ChromaW;
  localparam int ScW  = BinW + 4;

  logic [ThrW-1:0]               thr_q;
  logic                          in_valid_q;
  logic [NumBins-1:0][BinW-1:0]  bins_d, bins_q;
  logic                          sc_valid;
  logic [NumChords-1:0][ScW-1:0] sc_scaled;
  logic                          am_valid;
  logic [ScW-1:0]                am_scaled;
  logic [IdxW-1:0]               am_idx;
  logic                          cfg_wr;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Threshold register
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegIdxThr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegIdxThr) ? DataW'(thr_q) : '0;

  // Input register; bits above the chroma width are dropped
  always_comb begin
    bins_d[0]  = frame_i.chroma_c[BinW-1:0];
    bins_d[1]  = frame_i.chroma_cs[BinW-1:0];
    bins_d[2]  = frame_i.chroma_d[BinW-1:0];
    bins_d[3]  = frame_i.chroma_ds[BinW-1:0];
    bins_d[4]  = frame_i.chroma_e[BinW-1:0];
    bins_d[5]  = frame_i.chroma_f[BinW-1:0];
    bins_d[6]  = frame_i.chroma_fs[BinW-1:0];
    bins_d[7]  = frame_i.chroma_g[BinW-1:0];
    bins_d[8]  = frame_i.chroma_gs[BinW-1:0];
    bins_d[9]  = frame_i.chroma_a[BinW-1:0];
    bins_d[10] = frame_i.chroma_as[BinW-1:0];
    bins_d[11] = frame_i.chroma_b[BinW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      bins_q <= bins_d;
    end
  end

  ctm_score #(.BinW(BinW)) u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .bins_i   (bins_q),
    .valid_o  (sc_valid),
    .scaled_o (sc_scaled)
  );

  ctm_argmax #(.ScW(ScW)) u_argmax (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (sc_valid),
    .scaled_i      (sc_scaled),
    .valid_o       (am_valid),
    .best_scaled_o (am_scaled),
    .best_idx_o    (am_idx)
  );

  ctm_result #(.BinW(BinW)) u_result (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (am_valid),
    .scaled_i (am_scaled),
    .idx_i    (am_idx),
    .thr_i    (thr_q),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

### src/ctm_score.sv
// ----------------------------------------------------------------------------
// ctm_score
// Sums the template bins of all 36 chords, scaled to a common denominator 12.
// ----------------------------------------------------------------------------
module ctm_score import ctm_pkg::*; #(
  parameter int BinW = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [NumBins-1:0][BinW-1:0]    bins_i,
  output logic                            valid_o,
  output logic [NumChords-1:0][BinW+3:0]  scaled_o
);

  localparam int SumW = BinW + 2;
  localparam int ScW  = BinW + 4;

  logic [NumChords-1:0][ScW-1:0] scaled_d, scaled_q;
  logic                          valid_q;

  // Template sums: triads scaled by 4, seventh chords by 3
  always_comb begin
    logic [SumW-1:0]  s;
    logic [RootW-1:0] r;
    for (int i = 0; i < NumChords; i++) begin
      r = ChordRoot[i];
      s = SumW'(bins_i[r]) + SumW'(bins_i[pc_add(r, 4'd7)]);
      if (ChordQual[i] == QualMin) begin
        s = s + SumW'(bins_i[pc_add(r, 4'd3)]);
      end else begin
        s = s + SumW'(bins_i[pc_add(r, 4'd4)]);
      end
      if (ChordQual[i] == QualDom7) begin
        s = s + SumW'(bins_i[pc_add(r, 4'd10)]);
        scaled_d[i] = ScW'(s) + (ScW'(s) << 1);
      end else begin
        scaled_d[i] = ScW'(s) << 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    scaled_q <= scaled_d;
  end

  assign valid_o  = valid_q;
  assign scaled_o = scaled_q;

endmodule

### src/ctm_argmax.sv
// ----------------------------------------------------------------------------
// ctm_argmax
// Two-stage registered compare tree; picks the first chord with the top score.
// ----------------------------------------------------------------------------
module ctm_argmax import ctm_pkg::*; #(
  parameter int ScW = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [NumChords-1:0][ScW-1:0]  scaled_i,
  output logic                           valid_o,
  output logic [ScW-1:0]                 best_scaled_o,
  output logic [IdxW-1:0]                best_idx_o
);

  localparam int L1 = NumChords / 2;
  localparam int L2 = L1 / 2;
  localparam int L3 = (L2 + 1) / 2;

  typedef struct packed {
    logic [ScW-1:0]  scaled;
    logic [IdxW-1:0] idx;
  } cand_t;

  // Earlier candidate keeps the slot unless the later one is strictly larger
  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.scaled > a.scaled) ? b : a;
  endfunction

  cand_t       lvl0 [NumChords];
  cand_t       lvl1 [L1];
  cand_t       lvl2 [L2];
  cand_t       part_d [L3];
  cand_t       part_q [L3];
  cand_t       best_d, best_q;
  logic [1:0]  valid_q;

  // First half of the tree: 36 down to 5
  always_comb begin
    for (int i = 0; i < NumChords; i++) begin
      lvl0[i].scaled = scaled_i[i];
      lvl0[i].idx    = IdxW'(i);
    end
    for (int j = 0; j < L1; j++) begin
      lvl1[j] = pick(lvl0[2*j], lvl0[2*j+1]);
    end
    for (int j = 0; j < L2; j++) begin
      lvl2[j] = pick(lvl1[2*j], lvl1[2*j+1]);
    end
    for (int j = 0; j < L3 - 1; j++) begin
      part_d[j] = pick(lvl2[2*j], lvl2[2*j+1]);
    end
    part_d[L3-1] = lvl2[L2-1];
  end

  // Second half: 5 down to 1, order of the candidates kept
  always_comb begin
    cand_t a, b;
    a      = pick(part_q[0], part_q[1]);
    b      = pick(part_q[2], part_q[3]);
    best_d = pick(pick(a, b), part_q[4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    best_q <= best_d;
  end

  assign valid_o       = valid_q[1];
  assign best_scaled_o = best_q.scaled;
  assign best_idx_o    = best_q.idx;

endmodule

### src/ctm_result.sv
// ----------------------------------------------------------------------------
// ctm_result
// Threshold test, mean by reciprocal multiply, and the result register.
// ----------------------------------------------------------------------------
module ctm_result import ctm_pkg::*; #(
  parameter int BinW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [BinW+3:0]     scaled_i,
  input  logic [IdxW-1:0]     idx_i,
  input  logic [ThrW-1:0]     thr_i,
  output logic                valid_o,
  output chord_result_t       result_o
);

  localparam int ScW     = BinW + 4;
  localparam int DivW    = BinW + 2;
  localparam int K       = BinW + 3;
  localparam int RecipW  = K - 1;
  localparam int ProdW   = DivW + RecipW;
  localparam int ThrScW  = ThrW + 4;
  localparam logic [RecipW-1:0] Recip = RecipW'(((64'd1 << K) + 64'd2) / 64'd3);

  logic [ThrScW-1:0] thr_x12;
  logic [DivW-1:0]   quarter;
  logic [ProdW-1:0]  prod;
  logic              hit;
  chord_result_t     result_d, result_q;
  logic              valid_q;

  // scaled / 12 = floor(floor(scaled / 4) / 3), exact for this range
  assign quarter = scaled_i[ScW-1:2];
  assign prod    = ProdW'(quarter) * ProdW'(Recip);

  // Scores are in twelfths, so the threshold is too
  assign thr_x12 = (ThrScW'(thr_i) << 3) + (ThrScW'(thr_i) << 2);
  assign hit     = ThrScW'(scaled_i) > thr_x12;

  always_comb begin
    result_d.recognized    = hit;
    result_d.chord_root    = hit ? ChordRoot[idx_i] : '0;
    result_d.chord_quality = hit ? ChordQual[idx_i] : QualMaj;
    result_d.best_score    = ChromaW'(prod[K +: BinW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### src/ctm_checker.sv
// ----------------------------------------------------------------------------
// ctm_checker
// Port-level checks of the chord matcher: latency and result encoding.
// ----------------------------------------------------------------------------
`include "chord_template_matcher_defines.svh"

module ctm_checker import ctm_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_valid_o,
  input chord_result_t result_o
);

  // Every accepted frame yields a result beat
  `CTM_ASSERT(a_frame_to_result, clk_i, rst_ni, (start && !busy) |-> ##5 result_valid_o, "accepted frame without result beat")

  // No result beat without an earlier accepted frame
  `CTM_ASSERT(a_result_from_frame, clk_i, rst_ni, result_valid_o |-> $past(start && !busy, 5), "result beat without accepted frame")

  // Unrecognized frames report root and quality as zero
  `CTM_ASSERT(a_unknown_zero, clk_i, rst_ni, (result_valid_o && !result_o.recognized) |-> (result_o.chord_root == '0 && result_o.chord_quality == QualMaj), "unrecognized beat with chord set")

  // Recognized chords carry a legal root and quality
  `CTM_ASSERT(a_chord_legal, clk_i, rst_ni, (result_valid_o && result_o.recognized) |-> (result_o.chord_root <= 4'd11 && (result_o.chord_quality == QualMaj || result_o.chord_quality == QualMin || result_o.chord_quality == QualDom7)), "recognized beat with illegal chord")

endmodule

bind chord_template_matcher ctm_checker u_ctm_checker (.*);
